@@ rtl/core/pls_pkg.sv @@
// Shared types and constants for the positional list store.
// Used by pls_ctrl, pls_datapath and positional_list_store; depends on nothing.
package pls_pkg;

   localparam int OP_W       = 3;
   localparam int POS_W      = 6;
   localparam int VALUE_W    = 64;
   localparam int STATUS_W   = 2;
   localparam int LENGTH_W   = 7;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 80;

   typedef enum logic [OP_W-1:0] {
      OP_READ    = 3'd0,
      OP_APPEND  = 3'd1,
      OP_INSERT  = 3'd2,
      OP_DELETE  = 3'd3,
      OP_REPLACE = 3'd4,
      OP_CLEAR   = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_ABSENT  = 2'd1,
      ST_FULL    = 2'd2,
      ST_NO_NEXT = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_READ_WAIT,
      S_UP_TEST,
      S_UP_MOVE,
      S_DN_TEST,
      S_DN_MOVE,
      S_FINISH
   } state_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_POS,
      RD_PREV,
      RD_NEXT
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_TAIL,
      WR_AFTER,
      WR_MOVE
   } wr_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC,
      CNT_CLR
   } cnt_op_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_COUNT,
      IDX_FIRST,
      IDX_DEC,
      IDX_INC
   } idx_op_type;

   typedef struct packed {
      logic       capture;
      logic       latch_status;
      logic       load_read;
      logic       rsp_load;
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      cnt_op_type cnt_op;
      idx_op_type idx_op;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   ok;
      logic   has_next;
      logic   more_up;
      logic   more_dn;
      logic   out_free;
   } stat_type;

endpackage

@@ rtl/core/pls_ctrl.sv @@
// Sequencer for the positional list store: decodes each request and steps the
// datapath through reads, entry moves and the result hand-off. Uses pls_pkg.
module pls_ctrl
   import pls_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!stat.ok) begin
               state_in = S_FINISH;
            end else begin
               unique case (stat.op)
                  OP_READ:   state_in = S_READ_WAIT;
                  OP_INSERT: state_in = S_UP_TEST;
                  OP_DELETE: state_in = S_DN_TEST;
                  default:   state_in = S_FINISH;
               endcase
            end
         end
         S_READ_WAIT: state_in = S_FINISH;
         S_UP_TEST: begin
            state_in = stat.more_up ? S_UP_MOVE : S_FINISH;
         end
         S_UP_MOVE: state_in = S_UP_TEST;
         S_DN_TEST: begin
            state_in = stat.more_dn ? S_DN_MOVE : S_FINISH;
         end
         S_DN_MOVE: state_in = S_DN_TEST;
         S_FINISH: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd              = '0;
      cmd.rd_sel       = RD_NONE;
      cmd.wr_sel       = WR_NONE;
      cmd.cnt_op       = CNT_HOLD;
      cmd.idx_op       = IDX_HOLD;
      req_tready       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         S_DECODE: begin
            cmd.latch_status = 1'b1;
            if (stat.ok) begin
               unique case (stat.op)
                  OP_READ:   cmd.rd_sel = RD_POS;
                  OP_APPEND: begin
                     cmd.wr_sel = WR_TAIL;
                     cmd.cnt_op = CNT_INC;
                  end
                  OP_INSERT: cmd.idx_op = IDX_COUNT;
                  OP_DELETE: cmd.idx_op = IDX_FIRST;
                  OP_REPLACE: begin
                     if (stat.has_next) begin
                        cmd.wr_sel = WR_AFTER;
                     end else begin
                        cmd.wr_sel = WR_TAIL;
                        cmd.cnt_op = CNT_INC;
                     end
                  end
                  OP_CLEAR:  cmd.cnt_op = CNT_CLR;
                  default: ;
               endcase
            end
         end
         S_READ_WAIT: cmd.load_read = 1'b1;
         S_UP_TEST: begin
            if (stat.more_up) begin
               cmd.rd_sel = RD_PREV;
            end else begin
               // Every later entry has moved up: drop the new value in the gap.
               cmd.wr_sel = WR_AFTER;
               cmd.cnt_op = CNT_INC;
            end
         end
         S_UP_MOVE: begin
            cmd.wr_sel = WR_MOVE;
            cmd.idx_op = IDX_DEC;
         end
         S_DN_TEST: begin
            if (stat.more_dn) begin
               cmd.rd_sel = RD_NEXT;
            end else begin
               cmd.cnt_op = CNT_DEC;
            end
         end
         S_DN_MOVE: begin
            cmd.wr_sel = WR_MOVE;
            cmd.idx_op = IDX_INC;
         end
         S_FINISH: cmd.rsp_load = stat.out_free;
         default: ;
      endcase
   end

endmodule

@@ rtl/core/pls_datapath.sv @@
// Datapath of the positional list store: request registers, entry memory,
// length counter, move index and the result register. Uses pls_pkg.
module pls_datapath
   import pls_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [POS_W-1:0]      req_position,
   input  logic [VALUE_W-1:0]    req_new_value,
   input  cmd_type               cmd,
   output stat_type              stat,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [VALUE_W-1:0]    rsp_read_value,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [LENGTH_W-1:0]   rsp_length
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;
   localparam int XW = (CW > LENGTH_W) ? CW : LENGTH_W;

   // Current request.
   op_type             op_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [VALUE_W-1:0] val_ff;

   // List state and sequencing.
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [VALUE_W-1:0] entries_ff [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;
   status_type         status_ff;
   logic [VALUE_W-1:0] read_value_ff;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_read_value_ff;
   status_type         rsp_status_ff;
   logic [LENGTH_W-1:0] rsp_length_ff;

   logic [PW-1:0] pos_x, first_x, count_x, idx_x, idx_next_x;
   logic [XW-1:0] count_len;
   logic          present, full, has_next;
   status_type    status_code;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [CW-1:0] idx_dec, idx_inc;

   assign pos_x      = PW'(pos_ff);
   assign first_x    = pos_x + PW'(1);
   assign count_x    = PW'(count_ff);
   assign idx_x      = PW'(idx_ff);
   assign idx_next_x = idx_x + PW'(1);
   assign idx_dec    = idx_ff - CW'(1);
   assign idx_inc    = idx_ff + CW'(1);
   assign present    = pos_x < count_x;
   assign full       = count_x == PW'(DEPTH);
   assign has_next   = first_x < count_x;
   assign count_len  = XW'(count_ff);

   always_comb begin
      status_code = ST_DONE;
      unique case (op_ff)
         OP_READ: begin
            if (!present) status_code = ST_ABSENT;
         end
         OP_APPEND: begin
            if (full) status_code = ST_FULL;
         end
         OP_INSERT: begin
            if (!present)  status_code = ST_ABSENT;
            else if (full) status_code = ST_FULL;
         end
         OP_DELETE: begin
            if (!present)       status_code = ST_ABSENT;
            else if (!has_next) status_code = ST_NO_NEXT;
         end
         OP_REPLACE: begin
            // Replacing past the tail turns into an append.
            if (!present)                status_code = ST_ABSENT;
            else if (!has_next && full)  status_code = ST_FULL;
         end
         default: status_code = ST_DONE;
      endcase
   end

   assign stat.op       = op_ff;
   assign stat.ok       = status_code == ST_DONE;
   assign stat.has_next = has_next;
   assign stat.more_up  = idx_x > first_x;
   assign stat.more_dn  = idx_next_x < count_x;
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      unique case (cmd.rd_sel)
         RD_POS:  rd_addr = pos_x[AW-1:0];
         RD_PREV: rd_addr = idx_dec[AW-1:0];
         RD_NEXT: rd_addr = idx_inc[AW-1:0];
         default: rd_addr = pos_x[AW-1:0];
      endcase
   end

   always_comb begin
      wr_data = val_ff;
      unique case (cmd.wr_sel)
         WR_TAIL:  wr_addr = count_ff[AW-1:0];
         WR_AFTER: wr_addr = first_x[AW-1:0];
         WR_MOVE: begin
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_data_ff;
         end
         default:  wr_addr = count_ff[AW-1:0];
      endcase
   end

   always_comb begin
      unique case (cmd.cnt_op)
         CNT_INC: count_in = count_ff + CW'(1);
         CNT_DEC: count_in = count_ff - CW'(1);
         CNT_CLR: count_in = '0;
         default: count_in = count_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.idx_op)
         IDX_COUNT: idx_in = count_ff;
         IDX_FIRST: idx_in = first_x[CW-1:0];
         IDX_DEC:   idx_in = idx_dec;
         IDX_INC:   idx_in = idx_inc;
         default:   idx_in = idx_ff;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.capture) begin
         op_ff  <= op_type'(req_operation);
         pos_ff <= req_position;
         val_ff <= req_new_value;
      end
      if (cmd.latch_status) begin
         status_ff     <= status_code;
         read_value_ff <= '0;
      end else if (cmd.load_read) begin
         read_value_ff <= rd_data_ff;
      end
      if (cmd.rsp_load) begin
         rsp_read_value_ff <= read_value_ff;
         rsp_status_ff     <= status_ff;
         rsp_length_ff     <= count_len[LENGTH_W-1:0];
      end
   end

   // Entry memory: one write and one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.wr_sel != WR_NONE) begin
         entries_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_sel != RD_NONE) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_length     = rsp_length_ff;

endmodule

@@ rtl/core/positional_list_store.sv @@
// Top level of the positional list store: an ordered list of 64-bit values.
// Instantiates pls_ctrl and pls_datapath; uses pls_pkg.
//
// Each request on the req_ stream carries an operation (read, append, insert
// after, delete after, replace after, clear), a zero-based position and a new
// value, and yields one response on the rsp_ stream: the value read (zero
// unless a read succeeded), a status code and the list length afterwards.
// Requests that cannot be carried out leave the list as it was.
//
// Each request is decoded first. A read then waits for the registered memory
// read; append, replace, clear, unused codes and rejected requests go straight
// to the response. Insert and delete move entries one at a time, each read in
// one state and written in the next, as the entries sit in a memory with one
// write and one registered read port: an insert after position p moves
// length-p-1 entries, a delete after p moves length-p-2. A new request is
// taken in the cycle after its predecessor's response has been loaded.
// Reset clears the length to zero; the entry memory needs no clearing. The
// response has its own register, so a stalled receiver holds the block only
// when the next response is ready to leave.
module positional_list_store
   import pls_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [2:0] operation, [8:3] position, [72:9] new_value, [79:73] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [63:0] read_value, [65:64] status, [72:66] length, [79:73] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   cmd_type              cmd;
   stat_type             stat;
   logic [VALUE_W-1:0]   rsp_read_value;
   logic [STATUS_W-1:0]  rsp_status;
   logic [LENGTH_W-1:0]  rsp_length;

   pls_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pls_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_operation  (req_tdata[OP_W-1:0]),
      .req_position   (req_tdata[OP_W+POS_W-1:OP_W]),
      .req_new_value  (req_tdata[OP_W+POS_W+VALUE_W-1:OP_W+POS_W]),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_length     (rsp_length)
   );

   // Response fields packed from the lowest bit up, padded to whole bytes.
   assign rsp_tdata = {(RSP_DATA_W - VALUE_W - STATUS_W - LENGTH_W)'(0),
                       rsp_length, rsp_status, rsp_read_value};

endmodule
